FILE: design/pid_controller_three_forms_core_macros.svh
// Assertion macros for the PID regulator core.
// Plain text macros, no dependencies; included by the top level.
`ifndef PID_CONTROLLER_THREE_FORMS_CORE_MACROS_SVH
`define PID_CONTROLLER_THREE_FORMS_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PIDC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pidc_pkg.sv
// Shared types and constants for the PID regulator core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pidc_pkg;

	localparam int DataW   = 16;
	localparam int ErrW    = 17;
	localparam int AccW    = 32;
	localparam int CfgIdxW = 3;

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_MODE    = 3'd0,
		REG_KP      = 3'd1,
		REG_KI      = 3'd2,
		REG_KD      = 3'd3,
		REG_OUT_MIN = 3'd4,
		REG_OUT_MAX = 3'd5
	} reg_idx_t;

	// mode codes; the unused code behaves as proportional on measurement
	localparam logic [1:0] MODE_TIMESTEP = 2'd0;
	localparam logic [1:0] MODE_SIMPLE   = 2'd1;
	localparam logic [1:0] MODE_POM      = 2'd2;

	// request codes
	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [DataW-1:0]  kp;
		logic signed [DataW-1:0]  ki;
		logic signed [DataW-1:0]  kd;
		logic signed [DataW-1:0]  out_min;
		logic signed [DataW-1:0]  out_max;
	} cfg_t;

	typedef struct packed {
		logic signed [AccW-1:0]  integral_sum;
		logic signed [ErrW-1:0]  last_value;
	} pid_state_t;

endpackage

FILE: design/pidc_cfg.sv
// Configuration register file of the PID regulator core.
// Depends on pidc_pkg for the register indexes and the cfg_t layout.
`timescale 1ns / 1ps

module pidc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pidc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pidc_pkg::DataW-1:0]    cfg_data,
	output pidc_pkg::cfg_t                cfg
);
	import pidc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= MODE_POM;
			cfg_q.kp      <= '0;
			cfg_q.ki      <= '0;
			cfg_q.kd      <= '0;
			cfg_q.out_min <= 16'sh8000;
			cfg_q.out_max <= 16'sh7fff;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:    cfg_q.mode    <= cfg_data[1:0];
				REG_KP:      cfg_q.kp      <= cfg_data;
				REG_KI:      cfg_q.ki      <= cfg_data;
				REG_KD:      cfg_q.kd      <= cfg_data;
				REG_OUT_MIN: cfg_q.out_min <= cfg_data;
				REG_OUT_MAX: cfg_q.out_max <= cfg_data;
				default:     ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/pidc_calc.sv
// Single-pass PID arithmetic: error, three gain products, integral update,
// clamp and truncation. Depends on pidc_pkg for cfg_t and pid_state_t.
`timescale 1ns / 1ps

module pidc_calc (
	input  pidc_pkg::cfg_t                   cfg,
	input  pidc_pkg::pid_state_t             cur,
	input  logic                             req_type,
	input  logic signed [pidc_pkg::DataW-1:0] target,
	input  logic signed [pidc_pkg::DataW-1:0] measurement,
	output pidc_pkg::pid_state_t             nxt,
	output logic signed [pidc_pkg::DataW-1:0] drive
);
	import pidc_pkg::*;

	localparam int DeltaW = ErrW + 1;
	localparam int KiW    = DataW + AccW;
	localparam int KpW    = DataW + DeltaW;
	localparam int SumW   = KiW + 4;

	function automatic logic signed [AccW-1:0] sat32(input logic signed [SumW-1:0] v);
		logic all_one;
		logic all_zero;
		all_one  = &v[SumW-1:AccW-1];
		all_zero = ~|v[SumW-1:AccW-1];
		if (all_one || all_zero)
			sat32 = v[AccW-1:0];
		else if (v[SumW-1])
			sat32 = {1'b1, {(AccW-1){1'b0}}};
		else
			sat32 = {1'b0, {(AccW-1){1'b1}}};
	endfunction

	// upper test first, so crossed limits give out_max above it, out_min otherwise
	function automatic logic signed [SumW-1:0] clamp_q(
		input logic signed [SumW-1:0]  v,
		input logic signed [DataW-1:0] lo,
		input logic signed [DataW-1:0] hi
	);
		logic signed [SumW-1:0] hi_q;
		logic signed [SumW-1:0] lo_q;
		hi_q = SumW'(hi) <<< 8;
		lo_q = SumW'(lo) <<< 8;
		if (v > hi_q)
			clamp_q = hi_q;
		else if (v < lo_q)
			clamp_q = lo_q;
		else
			clamp_q = v;
	endfunction

	logic                       is_ts;
	logic                       is_simple;
	logic signed [ErrW-1:0]     err;
	logic signed [ErrW-1:0]     diff_src;
	logic signed [DeltaW-1:0]   delta;
	logic signed [AccW-1:0]     int_simple;
	logic signed [AccW-1:0]     ki_opnd;
	logic signed [DeltaW-1:0]   kp_opnd;
	logic signed [KiW-1:0]      ki_prod;
	logic signed [KpW-1:0]      kp_prod;
	logic signed [KpW-1:0]      kd_prod;
	logic signed [AccW-1:0]     int_ts;
	logic signed [SumW-1:0]     s_pom;
	logic signed [SumW-1:0]     v_sum;
	logic signed [SumW-1:0]     v_clamped;
	logic signed [SumW-1:0]     v_shift;
	logic signed [AccW-1:0]     int_next;

	assign is_ts     = (cfg.mode == MODE_TIMESTEP);
	assign is_simple = (cfg.mode == MODE_SIMPLE);

	assign err      = ErrW'(target) - ErrW'(measurement);
	// derivative runs on the error in simple mode, on the measurement otherwise
	assign diff_src = is_simple ? err : ErrW'(measurement);
	assign delta    = DeltaW'(diff_src) - DeltaW'(cur.last_value);

	assign int_simple = sat32(SumW'(cur.integral_sum) + SumW'(err));

	// ki scales the new sum in simple mode and the error elsewhere
	assign ki_opnd = is_simple ? int_simple : AccW'(err);
	assign kp_opnd = (is_ts || is_simple) ? DeltaW'(err) : delta;

	assign ki_prod = KiW'(cfg.ki) * KiW'(ki_opnd);
	assign kp_prod = KpW'(cfg.kp) * KpW'(kp_opnd);
	assign kd_prod = KpW'(cfg.kd) * KpW'(delta);

	assign int_ts = sat32(SumW'(cur.integral_sum) + SumW'(ki_prod));
	assign s_pom  = clamp_q(SumW'(cur.integral_sum) + SumW'(ki_prod) - SumW'(kp_prod),
		cfg.out_min, cfg.out_max);

	always_comb begin
		if (is_ts) begin
			int_next = int_ts;
			v_sum    = SumW'(kp_prod) + SumW'(int_ts) - SumW'(kd_prod);
		end else if (is_simple) begin
			int_next = int_simple;
			v_sum    = SumW'(kp_prod) + SumW'(ki_prod) + SumW'(kd_prod);
		end else begin
			int_next = s_pom[AccW-1:0];
			v_sum    = s_pom - SumW'(kd_prod);
		end
	end

	assign v_clamped = clamp_q(v_sum, cfg.out_min, cfg.out_max);
	// truncate toward zero: bump negative values that had fraction bits
	assign v_shift   = (v_clamped >>> 8) +
		SumW'(v_clamped[SumW-1] && (v_clamped[7:0] != 8'd0));

	always_comb begin
		if (req_type == REQ_CLEAR) begin
			nxt.integral_sum = '0;
			nxt.last_value   = '0;
			drive            = '0;
		end else begin
			nxt.integral_sum = int_next;
			nxt.last_value   = is_simple ? err : ErrW'(measurement);
			drive            = v_shift[DataW-1:0];
		end
	end

endmodule

FILE: design/pid_controller_three_forms_core.sv
// Top level of the PID regulator core: input register, regulator state,
// result register. Depends on pidc_pkg, pidc_cfg, pidc_calc and the macros header.
//
//   channel  dir  handshake             word
//   -------  ---  --------------------  -------------------------------
//   req      in   req_valid/req_stall   req_type, target, measurement
//   rsp      out  rsp_valid/rsp_stall   drive
//   cfg      in   cfg_we                cfg_index, cfg_data
//
// One word per cycle sustained while rsp does not stall; a taken word reaches rsp
// through the input register, the arithmetic, then the result register.
// The integral and last value update in the cycle a word leaves the input
// register, so the next word sees them at once.
// Reset clears the handshake, the state and loads the register defaults.
// A stalled rsp holds the result; req stalls only when both registers are full.
`timescale 1ns / 1ps

module pid_controller_three_forms_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pidc_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [pidc_pkg::DataW-1:0]         cfg_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic                               req_type,
	input  logic signed [pidc_pkg::DataW-1:0]  target,
	input  logic signed [pidc_pkg::DataW-1:0]  measurement,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic signed [pidc_pkg::DataW-1:0]  drive
);
	import pidc_pkg::*;

	`include "pid_controller_three_forms_core_macros.svh"

	cfg_t                     cfg;
	pid_state_t               state_q;
	pid_state_t               state_nxt;
	logic                     valid_s1;
	logic                     type_s1;
	logic signed [DataW-1:0]  target_s1;
	logic signed [DataW-1:0]  meas_s1;
	logic                     valid_s2;
	logic signed [DataW-1:0]  drive_s2;
	logic signed [DataW-1:0]  drive_calc;
	logic                     advance_s1;
	logic                     take_in;

	pidc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidc_calc u_calc (
		.cfg         (cfg),
		.cur         (state_q),
		.req_type    (type_s1),
		.target      (target_s1),
		.measurement (meas_s1),
		.nxt         (state_nxt),
		.drive       (drive_calc)
	);

	assign advance_s1 = valid_s1 && (!valid_s2 || !rsp_stall);
	assign take_in    = req_valid && !req_stall;
	assign req_stall  = valid_s1 && !advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			type_s1   <= req_type;
			target_s1 <= target;
			meas_s1   <= measurement;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			drive_s2 <= drive_calc;
		end
	end

	assign rsp_valid = valid_s2;
	assign drive     = drive_s2;

	`PIDC_ASSERT_NEXT(a_clear_gives_zero, clk, arst_n, advance_s1 && (type_s1 == REQ_CLEAR), rsp_valid && (drive == '0), "clear request did not produce a zero drive word")
	`PIDC_ASSERT_NEXT(a_clear_wipes_state, clk, arst_n, advance_s1 && (type_s1 == REQ_CLEAR), (state_q.integral_sum == '0) && (state_q.last_value == '0), "clear request left regulator state")
	`PIDC_ASSERT_SAME(a_stall_only_full, clk, arst_n, req_stall, valid_s1 && valid_s2 && rsp_stall, "req stalled with room in the pipeline")

endmodule
